[src/cba_pkg.sv]
// Package with shared types, codes and sizes for the contiguous block allocator.
package cba_pkg;

  localparam int DEPTH      = 128;
  localparam int DATA_WIDTH = 16;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  localparam logic [7:0] DISK_RESET = 8'd100;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_BUSY  = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [6:0]  base_block;
    logic [7:0]  run_length;
    logic [15:0] fill_data;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  granted_start;
    logic [15:0] block_word;
    logic        block_occupied;
    logic [6:0]  file_count;
    logic [7:0]  free_count;
  } rsp_t;

  typedef struct packed {
    logic                  rd_en;
    logic                  occ_we;
    logic                  occ_wdata;
    logic                  data_we;
    logic [DATA_WIDTH-1:0] data_wdata;
    logic [ADDR_W-1:0]     addr;
  } mem_req_t;

endpackage

[src/cba_ram.sv]
// Single-port synchronous RAM with registered read data.
module cba_ram #(
  parameter int WIDTH   = 1,
  parameter int DEPTH_P = 2
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic                       re,
  input  logic [$clog2(DEPTH_P)-1:0] addr,
  input  logic [WIDTH-1:0]           wdata,
  output logic [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH_P];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

[src/cba_ctrl.sv]
// Sequencer that walks the block memories for each request and sweeps the counts.
module cba_ctrl
  import cba_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic [7:0]            disk_blocks,
  input  logic                  in_valid,
  input  req_t                  in_data,
  output logic                  busy_out,
  input  logic                  out_free,
  output logic                  done,
  output rsp_t                  rsp,
  output mem_req_t              mem_req,
  input  logic                  occ_rdata,
  input  logic [DATA_WIDTH-1:0] data_rdata
);

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_CHECK = 9'b000000100,
    S_FILL  = 9'b000001000,
    S_FREE  = 9'b000010000,
    S_READ  = 9'b000100000,
    S_READW = 9'b001000000,
    S_SWEEP = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t           state;
  req_t             cur;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] size_q;
  logic [CNT_W-1:0] end_q;
  logic             pend;
  logic             hit;
  logic             prev;
  logic [1:0]       status;
  logic [6:0]       granted;
  logic [15:0]      word;
  logic             occ;
  logic [6:0]       files;
  logic [7:0]       frees;

  logic [CNT_W-1:0] size;
  logic [8:0]       range_end;
  logic             in_range;
  logic             rd;

  always_comb begin
    if (disk_blocks > 8'(DEPTH)) begin
      size = CNT_W'(DEPTH);
    end else begin
      size = CNT_W'(disk_blocks);
    end
    range_end = 9'(in_data.base_block) + 9'(in_data.run_length);
    in_range  = range_end <= 9'(size);
  end

  always_comb begin
    mem_req            = '0;
    mem_req.addr       = idx[ADDR_W-1:0];
    mem_req.data_wdata = cur.fill_data[DATA_WIDTH-1:0];
    rd                 = 1'b0;
    case (state)
      S_CLEAR: begin
        mem_req.occ_we = 1'b1;
      end
      S_CHECK: begin
        rd = idx != end_q;
      end
      S_FILL: begin
        mem_req.occ_we    = 1'b1;
        mem_req.occ_wdata = 1'b1;
        mem_req.data_we   = 1'b1;
      end
      S_FREE: begin
        mem_req.occ_we = 1'b1;
      end
      S_READ: begin
        rd = 1'b1;
      end
      S_SWEEP: begin
        rd = idx != size_q;
      end
      default: begin
        rd = 1'b0;
      end
    endcase
    mem_req.rd_en = rd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      idx   <= '0;
      pend  <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          idx <= idx + 1'b1;
          if (idx == CNT_W'(DEPTH - 1)) begin
            idx   <= '0;
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            cur     <= in_data;
            size_q  <= size;
            end_q   <= CNT_W'(range_end);
            status  <= ST_OK;
            granted <= '0;
            word    <= '0;
            occ     <= 1'b0;
            files   <= '0;
            frees   <= '0;
            prev    <= 1'b0;
            pend    <= 1'b0;
            hit     <= 1'b0;
            idx     <= '0;
            state   <= S_SWEEP;
            case (in_data.operation)
              OP_ALLOC: begin
                if (!in_range) begin
                  status <= ST_RANGE;
                end else if (in_data.run_length == 8'd0) begin
                  granted <= in_data.base_block;
                end else begin
                  idx   <= CNT_W'(in_data.base_block);
                  state <= S_CHECK;
                end
              end
              OP_FREE: begin
                if (!in_range) begin
                  status <= ST_RANGE;
                end else if (in_data.run_length != 8'd0) begin
                  idx   <= CNT_W'(in_data.base_block);
                  state <= S_FREE;
                end
              end
              OP_READ: begin
                if (CNT_W'(in_data.base_block) >= size) begin
                  status <= ST_RANGE;
                end else begin
                  idx   <= CNT_W'(in_data.base_block);
                  state <= S_READ;
                end
              end
              default: begin
                state <= S_SWEEP;
              end
            endcase
          end
        end
        S_CHECK: begin
          pend <= rd;
          if (rd) begin
            idx <= idx + 1'b1;
          end
          if (pend && occ_rdata) begin
            hit <= 1'b1;
          end
          if (!rd && !pend) begin
            if (hit) begin
              status <= ST_BUSY;
              idx    <= '0;
              state  <= S_SWEEP;
            end else begin
              granted <= cur.base_block;
              idx     <= CNT_W'(cur.base_block);
              state   <= S_FILL;
            end
          end
        end
        S_FILL, S_FREE: begin
          idx <= idx + 1'b1;
          if (idx + 1'b1 == end_q) begin
            idx   <= '0;
            state <= S_SWEEP;
          end
        end
        S_READ: begin
          state <= S_READW;
        end
        S_READW: begin
          occ   <= occ_rdata;
          word  <= occ_rdata ? 16'(data_rdata) : 16'd0;
          idx   <= '0;
          state <= S_SWEEP;
        end
        S_SWEEP: begin
          pend <= rd;
          if (rd) begin
            idx <= idx + 1'b1;
          end
          if (pend) begin
            prev <= occ_rdata;
            if (occ_rdata && !prev) begin
              files <= files + 1'b1;
            end
            if (!occ_rdata) begin
              frees <= frees + 1'b1;
            end
          end
          if (!rd && !pend) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_out = state != S_IDLE;
  assign done     = state == S_DONE;

  always_comb begin
    rsp.status         = status;
    rsp.granted_start  = granted;
    rsp.block_word     = word;
    rsp.block_occupied = occ;
    rsp.file_count     = files;
    rsp.free_count     = frees;
  end

endmodule

[src/contiguous_block_allocator.sv]
// Top level of the contiguous block allocator with memories and result register.
//
// Requests arrive on in_valid/in_stall/in_data and results leave on
// out_valid/out_stall/out_data; each channel moves one request when valid is
// high and stall is low. Every request yields exactly one result.
// The disk size register is written through cfg_write/cfg_data; the user must
// write it only while idle, as the block itself does not enforce this. The
// sequencer walks the single-port block memories one block per cycle. An
// allocate checks the range for occupied blocks, fills it, sweeps the occupancy
// map for the counts and hands the result over; a refused allocate skips the fill.
// A free clears the range and a read fetches one block; each then sweeps the map.
// A no-op or an out-of-disk request only sweeps the map before the hand-over.
// One request is in flight at a time; the next one can be taken once the
// previous result sits in the output register, even if it is still stalled.
// After reset the occupancy memory is cleared in a pass over all 128 blocks
// during which in_stall stays high; the disk size returns to 100 blocks.
// While out_valid and out_stall are both high the result register holds its value,
// and a further finished result waits in the sequencer until the register is free.
module contiguous_block_allocator
  import cba_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  req_t       in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output rsp_t       out_data
);

  logic [7:0]            disk_blocks;
  logic                  busy;
  logic                  done;
  logic                  out_free;
  rsp_t                  rsp;
  mem_req_t              mem_req;
  logic                  occ_rdata;
  logic [DATA_WIDTH-1:0] data_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      disk_blocks <= DISK_RESET;
    end else if (cfg_write) begin
      disk_blocks <= cfg_data;
    end
  end

  assign out_free = !out_valid || !out_stall;
  assign in_stall = busy;

  cba_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .disk_blocks(disk_blocks),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .busy_out   (busy),
    .out_free   (out_free),
    .done       (done),
    .rsp        (rsp),
    .mem_req    (mem_req),
    .occ_rdata  (occ_rdata),
    .data_rdata (data_rdata)
  );

  cba_ram #(
    .WIDTH  (1),
    .DEPTH_P(DEPTH)
  ) u_occ_ram (
    .clk  (clk),
    .we   (mem_req.occ_we),
    .re   (mem_req.rd_en),
    .addr (mem_req.addr),
    .wdata(mem_req.occ_wdata),
    .rdata(occ_rdata)
  );

  cba_ram #(
    .WIDTH  (DATA_WIDTH),
    .DEPTH_P(DEPTH)
  ) u_data_ram (
    .clk  (clk),
    .we   (mem_req.data_we),
    .re   (mem_req.rd_en),
    .addr (mem_req.addr),
    .wdata(mem_req.data_wdata),
    .rdata(data_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done && out_free) begin
      out_data <= rsp;
    end
  end

endmodule

[dv/contiguous_block_allocator_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the contiguous block allocator: directed and random requests.
module contiguous_block_allocator_test;
  import cba_pkg::*;

  localparam logic [1:0] OP_NOP = 2'd3;
  localparam int QUIET_LIMIT = 4000;
  localparam int TAIL_CYCLES = 300;

  logic clk;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [7:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rsp_t out_data;

  int idle_pct = 0;
  int stall_pct = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  int n_requests = 0;
  int n_ok = 0;
  int n_range = 0;
  int n_busy = 0;
  int n_hits = 0;

  logic [7:0] disk_reg = DISK_RESET;
  logic [DATA_WIDTH-1:0] block_data [DEPTH];
  bit used_map [DEPTH];
  rsp_t disk_replies [$];

  contiguous_block_allocator i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int disk_limit();
    return (disk_reg > DEPTH) ? DEPTH : int'(disk_reg);
  endfunction

  function automatic rsp_t apply_disk_op(req_t r);
    rsp_t rsp;
    int size;
    int first;
    int last;
    int files;
    int frees;
    bit prev;
    size = disk_limit();
    first = int'(r.base_block);
    last = first + int'(r.run_length);
    rsp = '0;
    files = 0;
    frees = 0;
    prev = 1'b0;
    case (r.operation)
      OP_ALLOC: begin
        if (last > size) begin
          rsp.status = ST_RANGE;
        end else begin
          for (int i = first; i < last; i++) begin
            if (used_map[i]) rsp.status = ST_BUSY;
          end
          if (rsp.status == ST_OK) begin
            for (int i = first; i < last; i++) begin
              block_data[i] = r.fill_data;
              used_map[i] = 1'b1;
            end
            rsp.granted_start = r.base_block;
          end
        end
      end
      OP_FREE: begin
        if (last > size) begin
          rsp.status = ST_RANGE;
        end else begin
          for (int i = first; i < last; i++) used_map[i] = 1'b0;
        end
      end
      OP_READ: begin
        if (first >= size) begin
          rsp.status = ST_RANGE;
        end else if (used_map[first]) begin
          rsp.block_occupied = 1'b1;
          rsp.block_word = block_data[first];
        end
      end
      default: begin
      end
    endcase
    for (int i = 0; i < size; i++) begin
      if (used_map[i] && !prev) files++;
      if (!used_map[i]) frees++;
      prev = used_map[i];
    end
    rsp.file_count = 7'(files);
    rsp.free_count = 8'(frees);
    return rsp;
  endfunction

  function automatic req_t make_op(logic [1:0] op, int first, int len, logic [15:0] fill);
    req_t r;
    r.operation = op;
    r.base_block = 7'(first);
    r.run_length = 8'(len);
    r.fill_data = fill;
    return r;
  endfunction

  // Most requests are in-disk ranges of a few blocks so that files build up and collide.
  function automatic req_t random_disk_op();
    req_t r;
    int size;
    int roll;
    int span;
    int len;
    int top;
    size = disk_limit();
    roll = $urandom_range(99);
    r.fill_data = 16'($urandom_range(65535));
    r.run_length = 8'($urandom_range(DEPTH));
    r.base_block = 7'($urandom_range(DEPTH - 1));
    if (roll < 5) begin
      r.operation = 2'($urandom_range(3));
    end else if (roll < 75) begin
      r.operation = (roll < 45) ? OP_ALLOC : OP_FREE;
      if ($urandom_range(9) != 0) begin
        span = ($urandom_range(4) == 0) ? size : ((size < 8) ? size : 8);
        len = $urandom_range(span);
        top = (size - len > DEPTH - 1) ? DEPTH - 1 : size - len;
        r.run_length = 8'(len);
        r.base_block = 7'($urandom_range(top));
      end
    end else begin
      r.operation = OP_READ;
      if (size > 0 && $urandom_range(9) != 0) r.base_block = 7'($urandom_range(size - 1));
    end
    return r;
  endfunction

  task automatic issue_disk_op(input req_t r);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (in_stall !== 1'b0);
    disk_replies.push_back(apply_disk_op(r));
    n_requests++;
  endtask

  task automatic wait_for_replies();
    in_valid <= 1'b0;
    while (disk_replies.size() != 0) @(posedge clk);
  endtask

  task automatic set_disk_size(input logic [7:0] value);
    wait_for_replies();
    repeat (4) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    disk_reg = value;
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic test_basic_operations();
    issue_disk_op(make_op(OP_READ, 0, 0, 16'h0000));
    issue_disk_op(make_op(OP_ALLOC, 0, 1, 16'hFFFF));
    issue_disk_op(make_op(OP_READ, 0, 128, 16'hFFFF));
    issue_disk_op(make_op(OP_ALLOC, 0, 3, 16'h1111));
    issue_disk_op(make_op(OP_ALLOC, 99, 1, 16'h0000));
    issue_disk_op(make_op(OP_ALLOC, 100, 0, 16'h2222));
    issue_disk_op(make_op(OP_ALLOC, 100, 1, 16'h3333));
    issue_disk_op(make_op(OP_ALLOC, 127, 128, 16'hFFFF));
    issue_disk_op(make_op(OP_READ, 100, 0, 16'h0000));
    issue_disk_op(make_op(OP_FREE, 0, 0, 16'h0000));
    issue_disk_op(make_op(OP_FREE, 50, 51, 16'h0000));
    issue_disk_op(make_op(OP_ALLOC, 10, 20, 16'hA5A5));
    issue_disk_op(make_op(OP_ALLOC, 40, 59, 16'h5A5A));
    issue_disk_op(make_op(OP_ALLOC, 29, 12, 16'h4444));
    issue_disk_op(make_op(OP_NOP, 127, 128, 16'hFFFF));
    issue_disk_op(make_op(OP_READ, 45, 0, 16'h0000));
    issue_disk_op(make_op(OP_FREE, 0, 100, 16'h0000));
    issue_disk_op(make_op(OP_READ, 127, 0, 16'h0000));
  endtask

  // Blocks above a shrunk disk must keep their contents until it grows again.
  task automatic test_disk_size_edges();
    set_disk_size(8'd255);
    issue_disk_op(make_op(OP_ALLOC, 120, 8, 16'h1234));
    issue_disk_op(make_op(OP_READ, 127, 0, 16'h0000));
    set_disk_size(8'd100);
    issue_disk_op(make_op(OP_READ, 127, 0, 16'h0000));
    set_disk_size(8'd0);
    issue_disk_op(make_op(OP_ALLOC, 0, 0, 16'h5555));
    issue_disk_op(make_op(OP_READ, 0, 0, 16'h0000));
    issue_disk_op(make_op(OP_FREE, 0, 1, 16'h0000));
    set_disk_size(8'd128);
    issue_disk_op(make_op(OP_READ, 127, 0, 16'h0000));
    issue_disk_op(make_op(OP_FREE, 0, 128, 16'h0000));
  endtask

  task automatic test_random_traffic(input int count, input logic [7:0] disk, input int idle,
                                     input int stall);
    set_disk_size(disk);
    idle_pct = idle;
    stall_pct = stall;
    repeat (count) issue_disk_op(random_disk_op());
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (disk_replies.size() == 0) begin
          $error("result arrived with no request outstanding");
          mismatches++;
        end else begin
          want = disk_replies.pop_front();
          check_field("status", want.status, out_data.status);
          check_field("granted_start", want.granted_start, out_data.granted_start);
          check_field("block_word", want.block_word, out_data.block_word);
          check_field("block_occupied", want.block_occupied, out_data.block_occupied);
          check_field("file_count", want.file_count, out_data.file_count);
          check_field("free_count", want.free_count, out_data.free_count);
          if (want.status == ST_RANGE) n_range++;
          else if (want.status == ST_BUSY) n_busy++;
          else n_ok++;
          if (want.block_occupied) n_hits++;
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $error("no request or result moved for %0d cycles", quiet_cycles);
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    block_data = '{default: '0};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_basic_operations();
    test_disk_size_edges();
    test_random_traffic(120, 8'd128, 0, 0);
    test_random_traffic(100, 8'd64, 86, 0);
    test_random_traffic(100, 8'd100, 0, 86);
    test_random_traffic(100, 8'd255, 27, 27);
    test_random_traffic(60, 8'd1, 27, 27);
    test_random_traffic(30, 8'd0, 86, 86);
    test_random_traffic(90, 8'($urandom_range(2, 127)), 0, 0);
    wait_for_replies();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d allocate, free, read and no-op requests over several disk sizes,",
             n_requests);
    $display("  %0d ok, %0d outside the disk, %0d refused as occupied, %0d occupied reads.",
             n_ok, n_range, n_busy, n_hits);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
